/* src/tcpr_pkg.sv */
`timescale 1ns / 1ps
package tcpr_pkg;

  // Coordinate width; all pixel positions wrap at this width.
  localparam int unsigned COORD_BITS     = 9;
  // Characters placed on a line before the next one forces a wrap.
  localparam int unsigned CHARS_PER_LINE = 16;
  localparam int unsigned GLYPH_SIZE     = 8;
  localparam int unsigned GLYPH_PIXELS   = GLYPH_SIZE * GLYPH_SIZE;
  localparam int unsigned LINE_CNT_BITS  = 5;
  localparam int unsigned ADDR_BITS      = 5;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [7:0] CODE_NEWLINE = 8'h0A;
  localparam logic [7:0] CODE_SPACE   = 8'h20;

  localparam logic [COORD_BITS-1:0] LINE_STEP = COORD_BITS'(GLYPH_SIZE);
  localparam logic [LINE_CNT_BITS-1:0] LINE_LIMIT = LINE_CNT_BITS'(CHARS_PER_LINE);

  typedef logic [COORD_BITS-1:0] coord_t;

  // Register indexes on the configuration port (byte address is 4 * index).
  typedef enum logic [2:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_TEXT_COLOR  = 3'd2,
    REG_BACK_COLOR  = 3'd3,
    REG_BACK_ENABLE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    coord_t      start_x;
    coord_t      start_y;
    logic [15:0] text_color;
    logic [15:0] back_color;
    logic        back_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [63:0] glyph_bits;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    coord_t      pixel_x;
    coord_t      pixel_y;
    logic [15:0] pixel_color;
    logic        last;
  } out_item_t;

  // One character to draw, handed from the front end to the pixel engine.
  typedef struct packed {
    coord_t                  base_x;
    coord_t                  base_y;
    logic [GLYPH_PIXELS-1:0] glyph;
    logic [GLYPH_PIXELS-1:0] mask;
  } job_t;

endpackage

/* src/text_cell_pixel_renderer_core.sv */
`timescale 1ns / 1ps
// Renders 8x8 bitmap characters into pixel writes, one write per beat on the
// result queue, in row-major order with last set on the final write of each
// character. The front end takes one character per cycle while its two-entry
// job queue has room, tracks the cursor, and handles newline and line wrap
// without producing writes. The pixel engine scans a glyph one position per
// cycle, except that a position that writes a pixel waits for the output
// register: a character is loaded as the previous one finishes, and its scan
// ends at its highest pixel written. Characters that write nothing never
// reach the engine. CHARS_PER_LINE sets how many characters fit on a line
// before a wrap. Configuration registers at byte addresses 0x00 start_x,
// 0x04 start_y, 0x08 text_color, 0x0C back_color, 0x10 back_enable.
module text_cell_pixel_renderer_core #(
  parameter int unsigned CHARS_PER_LINE = tcpr_pkg::CHARS_PER_LINE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  tcpr_pkg::in_item_t             in_data,
  output logic                           empty,
  input  logic                           pop,
  output tcpr_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcpr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  tcpr_pkg::cfg_t cfg;
  tcpr_pkg::job_t job_in, job_out;
  logic           job_push, q_full, q_valid, job_pop;

  tcpr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcpr_front #(
    .CHARS_PER_LINE (CHARS_PER_LINE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .push     (push),
    .in_data  (in_data),
    .q_full   (q_full),
    .full     (full),
    .job_push (job_push),
    .job      (job_in)
  );

  tcpr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (q_full),
    .rd_en   (job_pop),
    .valid   (q_valid),
    .rd_data (job_out)
  );

  tcpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (q_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

/* src/tcpr_regs.sv */
`timescale 1ns / 1ps
module tcpr_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcpr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output tcpr_pkg::cfg_t                 cfg
);

  tcpr_pkg::cfg_t   cfg_r;
  tcpr_pkg::cfg_t   cfg_nxt;
  tcpr_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = tcpr_pkg::reg_idx_t'(paddr[tcpr_pkg::ADDR_BITS-1:2]);
  assign cfg    = cfg_r;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        tcpr_pkg::REG_START_X:     cfg_nxt.start_x     = pwdata[tcpr_pkg::COORD_BITS-1:0];
        tcpr_pkg::REG_START_Y:     cfg_nxt.start_y     = pwdata[tcpr_pkg::COORD_BITS-1:0];
        tcpr_pkg::REG_TEXT_COLOR:  cfg_nxt.text_color  = pwdata[15:0];
        tcpr_pkg::REG_BACK_COLOR:  cfg_nxt.back_color  = pwdata[15:0];
        tcpr_pkg::REG_BACK_ENABLE: cfg_nxt.back_enable = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_x     <= '0;
      cfg_r.start_y     <= '0;
      cfg_r.text_color  <= 16'hFFFF;
      cfg_r.back_color  <= '0;
      cfg_r.back_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read mux.
  always_comb begin
    prdata = '0;
    unique case (idx)
      tcpr_pkg::REG_START_X:     prdata = 32'(cfg_r.start_x);
      tcpr_pkg::REG_START_Y:     prdata = 32'(cfg_r.start_y);
      tcpr_pkg::REG_TEXT_COLOR:  prdata = 32'(cfg_r.text_color);
      tcpr_pkg::REG_BACK_COLOR:  prdata = 32'(cfg_r.back_color);
      tcpr_pkg::REG_BACK_ENABLE: prdata = 32'(cfg_r.back_enable);
      default:                   prdata = '0;
    endcase
  end

endmodule

/* src/tcpr_front.sv */
`timescale 1ns / 1ps
module tcpr_front #(
  parameter int unsigned CHARS_PER_LINE = tcpr_pkg::CHARS_PER_LINE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tcpr_pkg::cfg_t     cfg,
  input  logic               push,
  input  tcpr_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               full,
  output logic               job_push,
  output tcpr_pkg::job_t     job
);

  // Characters placed on a line before the next one forces a wrap.
  localparam logic [tcpr_pkg::LINE_CNT_BITS-1:0] LINE_LIMIT =
    tcpr_pkg::LINE_CNT_BITS'(CHARS_PER_LINE);

  tcpr_pkg::coord_t                     cursor_x_r, cursor_x_nxt;
  tcpr_pkg::coord_t                     cursor_y_r, cursor_y_nxt;
  logic [tcpr_pkg::LINE_CNT_BITS-1:0]   line_chars_r, line_chars_nxt;
  tcpr_pkg::coord_t                     cx, cy;
  logic [tcpr_pkg::LINE_CNT_BITS-1:0]   lc;
  logic                                 accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Classify the char and move the cursor; one per cycle unless q_full.
  always_comb begin
    cursor_x_nxt   = cursor_x_r;
    cursor_y_nxt   = cursor_y_r;
    line_chars_nxt = line_chars_r;
    job_push       = 1'b0;
    cx = in_data.restart ? cfg.start_x : cursor_x_r;
    cy = in_data.restart ? cfg.start_y : cursor_y_r;
    lc = in_data.restart ? '0 : line_chars_r;
    job.base_x = cx;
    job.base_y = cy;
    job.glyph  = in_data.glyph_bits;
    job.mask   = in_data.glyph_bits | {tcpr_pkg::GLYPH_PIXELS{cfg.back_enable}};
    if (accept) begin
      if (in_data.char_code == tcpr_pkg::CODE_NEWLINE) begin
        cursor_x_nxt   = cfg.start_x;
        cursor_y_nxt   = cy + tcpr_pkg::LINE_STEP;
        line_chars_nxt = '0;
      end else begin
        // A full line wraps before the character is placed.
        if (lc >= LINE_LIMIT) begin
          cx = cfg.start_x;
          cy = cy + tcpr_pkg::LINE_STEP;
          lc = '0;
        end
        job.base_x = cx;
        job.base_y = cy;
        if (line_chars_r >= LINE_LIMIT && !in_data.restart &&
            in_data.char_code == tcpr_pkg::CODE_SPACE) begin
          // A space that would open the new line is dropped.
          cursor_x_nxt   = cx;
          cursor_y_nxt   = cy;
          line_chars_nxt = '0;
        end else begin
          cursor_x_nxt   = cx + tcpr_pkg::LINE_STEP;
          cursor_y_nxt   = cy;
          line_chars_nxt = lc + 1'b1;
          job_push       = (job.mask != '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      line_chars_r <= '0;
    end else begin
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
      line_chars_r <= line_chars_nxt;
    end
  end

endmodule

/* src/tcpr_queue.sv */
`timescale 1ns / 1ps
module tcpr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  tcpr_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output logic           valid,
  output tcpr_pkg::job_t rd_data
);

  localparam int unsigned PTR_BITS = $clog2(tcpr_pkg::QUEUE_DEPTH);

  tcpr_pkg::job_t                 slot_r [tcpr_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [PTR_BITS:0]              count_r, count_nxt;
  logic                           do_wr, do_rd;

  assign full    = (count_r == (PTR_BITS+1)'(tcpr_pkg::QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = slot_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_BITS+1)'(do_wr) - (PTR_BITS+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* src/tcpr_back.sv */
`timescale 1ns / 1ps
module tcpr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tcpr_pkg::cfg_t      cfg,
  input  logic                job_valid,
  input  tcpr_pkg::job_t      job,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output tcpr_pkg::out_item_t out_data
);

  localparam int unsigned IDX_BITS = $clog2(tcpr_pkg::GLYPH_PIXELS);
  localparam int unsigned COL_BITS = $clog2(tcpr_pkg::GLYPH_SIZE);

  logic                                busy_r, busy_nxt;
  logic [tcpr_pkg::GLYPH_PIXELS-1:0]   rem_r, rem_nxt;
  logic [tcpr_pkg::GLYPH_PIXELS-1:0]   glyph_r, glyph_nxt;
  logic [IDX_BITS-1:0]                 idx_r, idx_nxt;
  tcpr_pkg::coord_t                    base_x_r, base_x_nxt;
  tcpr_pkg::coord_t                    base_y_r, base_y_nxt;
  logic                                out_valid_r, out_valid_nxt;
  tcpr_pkg::out_item_t                 out_r, out_nxt;
  logic                                slot_free, advance, final_bit, load;

  assign empty     = !out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || pop;
  // A position that writes a pixel waits for the output register.
  assign advance   = busy_r && (!rem_r[0] || slot_free);
  assign final_bit = (rem_r[tcpr_pkg::GLYPH_PIXELS-1:1] == '0);
  assign load      = job_valid && (!busy_r || (advance && final_bit));
  assign job_pop   = load;

  // Scan one position per cycle; set mask bits write once the output is free.
  always_comb begin
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    glyph_nxt     = glyph_r;
    idx_nxt       = idx_r;
    base_x_nxt    = base_x_r;
    base_y_nxt    = base_y_r;
    out_valid_nxt = out_valid_r && !pop;
    out_nxt       = out_r;
    if (advance) begin
      rem_nxt   = rem_r >> 1;
      glyph_nxt = glyph_r >> 1;
      idx_nxt   = idx_r + 1'b1;
      busy_nxt  = !final_bit;
      if (rem_r[0]) begin
        out_valid_nxt       = 1'b1;
        out_nxt.pixel_x     = base_x_r + tcpr_pkg::COORD_BITS'(idx_r[COL_BITS-1:0]);
        out_nxt.pixel_y     = base_y_r + tcpr_pkg::COORD_BITS'(idx_r[IDX_BITS-1:COL_BITS]);
        out_nxt.pixel_color = glyph_r[0] ? cfg.text_color : cfg.back_color;
        out_nxt.last        = final_bit;
      end
    end
    if (load) begin
      busy_nxt   = 1'b1;
      rem_nxt    = job.mask;
      glyph_nxt  = job.glyph;
      idx_nxt    = '0;
      base_x_nxt = job.base_x;
      base_y_nxt = job.base_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    glyph_r  <= glyph_nxt;
    idx_r    <= idx_nxt;
    base_x_r <= base_x_nxt;
    base_y_r <= base_y_nxt;
    out_r    <= out_nxt;
  end

endmodule
